@@ sv/assert_macros.svh @@
// Assertion helpers for the trial-division block.
// Both expect a signal named clk in the calling scope; PTD_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ptd_pkg.sv @@
package ptd_pkg;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_NEITHER   = 2'd0;
  localparam verdict_t VERDICT_PRIME     = 2'd1;
  localparam verdict_t VERDICT_COMPOSITE = 2'd2;

  // Small primes handled by the screen and the first wheel divisor.
  localparam int EVEN_PRIME  = 2;
  localparam int ODD_PRIME   = 3;
  localparam int WHEEL_FIRST = 5;

  // Controller -> datapath
  typedef struct packed {
    logic     load;        // capture input value
    logic     init3;       // divisor := 3
    logic     adv;         // step divisor along the 6k+-1 wheel
    logic     div_start;   // start x mod d
    logic     set_verdict; // latch verdict
    verdict_t verdict;
    logic     out_load;    // move verdict into output register
  } ptd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic     early;         // verdict known without trial division
    verdict_t early_verdict;
    logic     div_done;
    logic     rem_zero;
    logic     bound_ok;      // d*d <= x
  } ptd_sts_t;

endpackage

@@ sv/ptd_dp.sv @@
module ptd_dp import ptd_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NUM_WIDTH-1:0] value,
  input  ptd_cmd_t             cmd,
  output ptd_sts_t             sts,
  output verdict_t             out_verdict
);

  localparam int NW = NUM_WIDTH;
  localparam int SW = NUM_WIDTH + 1;
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NW-1:0] x_r, x_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic          step4_r, step4_nxt;
  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  verdict_t      verdict_r, verdict_nxt;
  verdict_t      outv_r, outv_nxt;

  logic [NW:0]   rem_sh;
  logic [NW:0]   rem_sub;
  logic [SW-1:0] d_ext;

  assign rem_sh  = {rem_r, dvd_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign d_ext   = SW'(d_r);

  // screen: sign, <= 1, 2 and 3, even
  always_comb begin
    sts.early         = 1'b1;
    sts.early_verdict = VERDICT_NEITHER;
    if (x_r[NW-1] || x_r <= NW'(1)) begin
      sts.early_verdict = VERDICT_NEITHER;
    end else if (x_r == NW'(EVEN_PRIME) || x_r == NW'(ODD_PRIME)) begin
      sts.early_verdict = VERDICT_PRIME;
    end else if (!x_r[0]) begin
      sts.early_verdict = VERDICT_COMPOSITE;
    end else begin
      sts.early = 1'b0;
    end
  end

  assign sts.div_done = (cnt_r == '0);
  assign sts.rem_zero = (rem_r == '0);
  assign sts.bound_ok = (sq_r <= {1'b0, x_r});

  always_comb begin
    x_nxt       = x_r;
    d_nxt       = d_r;
    sq_nxt      = sq_r;
    step4_nxt   = step4_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    verdict_nxt = verdict_r;
    outv_nxt    = outv_r;

    if (cmd.load) x_nxt = value;
    if (cmd.init3) d_nxt = NW'(ODD_PRIME);

    if (cmd.adv) begin
      if (d_r == NW'(ODD_PRIME)) begin
        d_nxt     = NW'(WHEEL_FIRST);
        sq_nxt    = SW'(WHEEL_FIRST * WHEEL_FIRST);
        step4_nxt = 1'b0;
      end else if (step4_r) begin
        // (d+4)^2 = d^2 + 8d + 16
        d_nxt     = d_r + NW'(4);
        sq_nxt    = sq_r + (d_ext << 3) + SW'(16);
        step4_nxt = 1'b0;
      end else begin
        // (d+2)^2 = d^2 + 4d + 4
        d_nxt     = d_r + NW'(2);
        sq_nxt    = sq_r + (d_ext << 2) + SW'(4);
        step4_nxt = 1'b1;
      end
    end

    // restoring remainder, one dividend bit per cycle
    if (cmd.div_start) begin
      dvd_nxt = x_r;
      rem_nxt = '0;
      cnt_nxt = CW'(NUM_WIDTH);
    end else if (cnt_r != '0) begin
      rem_nxt = rem_sub[NW] ? rem_sh[NW-1:0] : rem_sub[NW-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - CW'(1);
    end

    if (cmd.set_verdict) verdict_nxt = cmd.verdict;
    if (cmd.out_load) outv_nxt = verdict_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    d_r       <= d_nxt;
    sq_r      <= sq_nxt;
    step4_r   <= step4_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    verdict_r <= verdict_nxt;
    outv_r    <= outv_nxt;
  end

  assign out_verdict = outv_r;

endmodule

@@ sv/ptd_ctrl.sv @@
module ptd_ctrl import ptd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ptd_sts_t sts,
  output ptd_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCREEN = 5'b00010,
    S_DIV    = 5'b00100,
    S_STEP   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.verdict = VERDICT_NEITHER;
    ovalid_nxt = ovalid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCREEN;
        end
      end
      S_SCREEN: begin
        if (sts.early) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = sts.early_verdict;
          state_nxt       = S_DONE;
        end else begin
          cmd.init3     = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            cmd.set_verdict = 1'b1;
            cmd.verdict     = VERDICT_COMPOSITE;
            state_nxt       = S_DONE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (sts.bound_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = VERDICT_PRIME;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

@@ sv/primality_trial_division.sv @@
// Primality classifier by trial division over the 6k-1 / 6k+1 wheel.
// Input channel in_*: one item per integer; in_tdata[NUM_WIDTH-1:0] is the
//   value, two's complement (bits above NUM_WIDTH, if any, are ignored).
// Output channel out_*: one item per input; out_tdata[1:0] is the verdict
//   (0 neither, 1 prime, 2 composite), upper bits zero.
// One item is worked on at a time; in_tready is high only when idle.
// Sequence, from the accepting edge: a screen step first (negatives, 0, 1, 2,
//   3 and even values finish here), then one trial per divisor (3, then 5, 7,
//   11, 13, ...). A trial runs the bit-serial remainder unit, then a step
//   that advances the divisor and tests d*d <= x (d*d kept incrementally, no
//   multiplier). After the last trial the verdict is loaded into the output
//   register and out_tvalid rises; the block then returns to idle and can
//   take the next item. A 31-bit prime tries about 15.4k divisors.
// A finished verdict sits in an output register, so the next item is
//   accepted while it waits; a stalled receiver only holds the block once a
//   second verdict is ready and the first has not been taken.
// Reset (rst_n, synchronous, active low) empties the output register and
//   returns the controller to idle; an item in flight is dropped.
`include "assert_macros.svh"

module primality_trial_division import ptd_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((NUM_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // [NUM_WIDTH-1:0] value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata   // [1:0] verdict
);

  ptd_cmd_t cmd;
  ptd_sts_t sts;
  verdict_t verdict;

  // controller: sequencing and handshakes
  ptd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: operand, wheel divisor, d^2 tracker, remainder unit
  ptd_dp #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .value       (in_tdata[NUM_WIDTH-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_verdict (verdict)
  );

  assign out_tdata = {6'b0, verdict};

  // ---- assertions ----
  // an accepted item keeps the block busy for at least the next cycle
  `PTD_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "accepted while busy")
  // the remainder unit never reports done right after a start
  `PTD_ASSERT(a_div_runs, cmd.div_start |=> !sts.div_done, "divider done too early")
  // verdict code 3 is never shown
  `PTD_ASSERT(a_verdict_code, out_tvalid |-> (out_tdata[1:0] <= VERDICT_COMPOSITE), "bad verdict")
  // reset empties the output
  `PTD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench import ptd_pkg::*; ();

  localparam int NUM_WIDTH  = 32;
  localparam int IN_BITS    = ((NUM_WIDTH + 7) / 8) * 8;
  localparam int CYCLE_CAP  = 5_000_000;  // run cap; a 31-bit prime is the slowest single item
  localparam int RAND_ITEMS = 76;
  localparam int HOLD_AT    = 30;         // items taken before the long receiver stall
  localparam int HOLD_LEN   = 20_000;     // outlasts two of the slowest random items
  localparam int DRAIN      = 100;

  typedef logic [NUM_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t   value;
    verdict_t verdict;
  } verdict_due_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_BITS-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;

  value_t       value_backlog [$];
  verdict_due_t due_verdicts  [$];
  int           items_taken   = 0;
  int           cycle_count   = 0;
  int           hold_left     = 0;
  bit           hold_done     = 1'b0;
  int           errors        = 0;

  primality_trial_division #(.NUM_WIDTH(NUM_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [NUM_WIDTH-1:0] value
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)    // [1:0] verdict
  );

  always #10 clk = ~clk;

  // Wheel trial division, exact bound d <= x / d.
  function automatic verdict_t classify_value(value_t x);
    value_t d;
    bit     step_four;
    if (x[NUM_WIDTH-1]) return VERDICT_NEITHER;
    if (x <= 1) return VERDICT_NEITHER;
    if (x == EVEN_PRIME || x == ODD_PRIME) return VERDICT_PRIME;
    if (x % EVEN_PRIME == 0 || x % ODD_PRIME == 0) return VERDICT_COMPOSITE;
    d = WHEEL_FIRST;
    step_four = 1'b0;
    while (d <= x / d) begin
      if (x % d == 0) return VERDICT_COMPOSITE;
      d = d + (step_four ? 4 : 2);
      step_four = !step_four;
    end
    return VERDICT_PRIME;
  endfunction

  // Idle odds per phase: sender 34 / receiver 54, then swapped, then none.
  function automatic int sender_idle_pct(int taken);
    if (taken < 45) return 34;
    if (taken < 90) return 54;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(int taken);
    if (taken < 45) return 54;
    if (taken < 90) return 34;
    return 0;
  endfunction

  // Mostly cheap values; large ones are negative or carry a factor <= 13 so
  // the divisor loop ends fast. Medium values bound the slow cases.
  function automatic value_t random_value();
    value_t v;
    int     f;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 4095);
      4:          v = $urandom_range(4096, 1 << 18);
      5, 6: begin
        f = $urandom_range(2, 13);
        v = f * $urandom_range(1, 32'h7FFF_FFFF / f);
      end
      7: begin
        v = $urandom();
        v[NUM_WIDTH-1] = 1'b1;
      end
      8:       v = $urandom_range(0, 40);
      default: begin
        f = $urandom_range(2, 300);
        v = f * f;
      end
    endcase
    return v;
  endfunction

  // Driver: offers the next backlog item, expectation recorded on accept.
  always @(posedge clk) begin
    verdict_due_t due_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_item.value   = in_tdata[NUM_WIDTH-1:0];
        due_item.verdict = classify_value(in_tdata[NUM_WIDTH-1:0]);
        due_verdicts.insert(due_verdicts.size(), due_item);
        items_taken <= items_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (value_backlog.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(items_taken)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= value_backlog.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver stall so the output register fills and in_tready drops.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: each verdict against the oldest expectation.
  always @(posedge clk) begin
    verdict_due_t due;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict item: expected none, got %0d",
                   $time, out_tdata[1:0]);
          errors++;
        end else begin
          due = due_verdicts.pop_front();
          if (out_tdata[1:0] !== due.verdict) begin
            $display("%0t: verdict for value %0d: expected %0d, got %0d",
                     $time, $signed(due.value), due.verdict, out_tdata[1:0]);
            errors++;
          end
          if (out_tdata[7:2] !== 6'd0) begin
            $display("%0t: padding bits for value %0d: expected 0, got %0h",
                     $time, $signed(due.value), out_tdata[7:2]);
            errors++;
          end
        end
      end
      out_tready <= (hold_left == 0) &&
                    ($urandom_range(0, 99) >= receiver_idle_pct(items_taken));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("primality_trial_division verification failed");
      $finish;
    end
  end

  initial begin
    // Corners: sign extremes, screen cases, first squares on the wheel,
    // the largest positive value (a prime, worst case) and its even neighbor.
    value_backlog = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9,
                      32'd25, 32'd35, 32'd49, 32'd97, 32'd121, 32'd143, 32'd169,
                      32'd289, 32'd65537, 32'd1000003, 32'h5555_5555,
                      32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'hAAAA_AAAA, 32'hFFFF_FFFF};
    for (int i = 0; i < RAND_ITEMS; i++) begin
      value_backlog.insert(value_backlog.size(), random_value());
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (value_backlog.size() != 0 || in_tvalid) @(posedge clk);
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0 && due_verdicts.size() == 0) begin
      $display("primality_trial_division verification clean");
    end else begin
      $display("primality_trial_division verification failed");
    end
    $finish;
  end

endmodule
